### src/qcd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_pkg
// Shared types, op codes and constants of the chunk decoder.
// ----------------------------------------------------------------------------
package qcd_pkg;

  localparam int INDEX_SIZE = 64;
  localparam int IDX_W      = $clog2(INDEX_SIZE);
  localparam int PIX_W      = 32;
  localparam int RUN_W      = 7;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_RGB  = 2'd1;
  localparam logic [1:0] OP_RGBA = 2'd2;
  localparam logic [1:0] OP_LUMA = 2'd3;

  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  localparam logic [7:0] BYTE_RGB  = 8'hfe;
  localparam logic [7:0] BYTE_RGBA = 8'hff;

  localparam logic [PIX_W-1:0] RESET_PX = 32'h0000_00ff;

  typedef struct packed {
    logic accept;
    logic decode;
    logic idx_load;
    logic emit;
  } qcd_cmd_t;

  typedef struct packed {
    logic dec_idx;
    logic dec_emit;
    logic slot_free;
    logic emit_last;
  } qcd_sts_t;

endpackage

### src/qcd_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd channel interfaces
// Byte input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
interface qcd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       image_start;

  modport source (output valid, data_byte, image_start, input ready);
  modport sink (input valid, data_byte, image_start, output ready);
endinterface

interface qcd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic [7:0] alpha;
  logic       last_of_run;
  logic       image_done;

  modport source (output valid, red, green, blue, alpha, last_of_run, image_done,
                  input ready);
  modport sink (input valid, red, green, blue, alpha, last_of_run, image_done,
                output ready);
endinterface

interface qcd_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] total_pixels;

  modport source (output valid, total_pixels, input ready);
  modport sink (input valid, total_pixels, output ready);
endinterface

### src/qoi_chunk_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qoi_chunk_decoder
// Decodes the chunk stream of an image, one byte per beat, into pixels.
// ----------------------------------------------------------------------------
// One byte is taken per beat and decoded before the next is taken. The
// sequencer steps a byte that ends no pixel through accept and decode, a
// diff, luma, rgb or rgba pixel also through emit, an index pixel also
// through one registered read of the 64-entry color index memory, and a run
// of n pixels through n emits at one pixel per cycle; any emit waits while
// the output beat is not taken. Index entries carry valid bits cleared at
// reset and at image start, so there is no clearing pass. The pixel count
// is written on the cfg channel and applies at the next image_start byte.
module qoi_chunk_decoder (
  input  logic       clk,
  input  logic       rst_n,
  qcd_in_if.sink     in_bus,
  qcd_out_if.source  out_bus,
  qcd_cfg_if.sink    cfg_bus
);
  import qcd_pkg::*;

  qcd_cmd_t cmd;
  qcd_sts_t sts;

  assign cfg_bus.ready = 1'b1;

  qcd_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_bus.valid),
    .in_ready (in_bus.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  qcd_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .cfg_we    (cfg_bus.valid),
    .cfg_total (cfg_bus.total_pixels),
    .in_byte   (in_bus.data_byte),
    .in_start  (in_bus.image_start),
    .out_ready (out_bus.ready),
    .out_valid (out_bus.valid),
    .out_red   (out_bus.red),
    .out_green (out_bus.green),
    .out_blue  (out_bus.blue),
    .out_alpha (out_bus.alpha),
    .out_last  (out_bus.last_of_run),
    .out_done  (out_bus.image_done)
  );

endmodule

### src/qcd_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_ctrl
// Sequencer: accept, decode, index read and pixel emit steps.
// ----------------------------------------------------------------------------
module qcd_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qcd_pkg::qcd_sts_t sts,
  output qcd_pkg::qcd_cmd_t cmd
);
  import qcd_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_DECODE = 2'd1;
  localparam logic [1:0] S_INDEX  = 2'd2;
  localparam logic [1:0] S_EMIT   = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt    = state_r;
    in_ready     = 1'b0;
    cmd          = '0;
    unique case (state_r)
      S_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        cmd.decode = 1'b1;
        priority if (sts.dec_idx) begin
          state_nxt = S_INDEX;
        end else if (sts.dec_emit) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_INDEX: begin
        cmd.idx_load = 1'b1;
        state_nxt    = S_EMIT;
      end
      S_EMIT: begin
        cmd.emit = sts.slot_free;
        if (sts.slot_free && sts.emit_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### src/qcd_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_datapath
// Op decode, pixel arithmetic, color index memory and output register.
// ----------------------------------------------------------------------------
module qcd_datapath (
  input  logic              clk,
  input  logic              rst_n,
  input  qcd_pkg::qcd_cmd_t cmd,
  output qcd_pkg::qcd_sts_t sts,
  input  logic              cfg_we,
  input  logic [31:0]       cfg_total,
  input  logic [7:0]        in_byte,
  input  logic              in_start,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [7:0]        out_red,
  output logic [7:0]        out_green,
  output logic [7:0]        out_blue,
  output logic [7:0]        out_alpha,
  output logic              out_last,
  output logic              out_done
);
  import qcd_pkg::*;

  logic [PIX_W-1:0]      mem [INDEX_SIZE];
  logic [INDEX_SIZE-1:0] vld_r;
  logic [PIX_W-1:0]      rd_r;
  logic                  rd_vld_r;

  logic [31:0]      total_r;
  logic [7:0]       byte_r;
  logic [PIX_W-1:0] prev_r, pix_r, part_r;
  logic [1:0]       pend_r;
  logic [2:0]       cnt_r;
  logic [31:0]      left_r;
  logic [RUN_W-1:0] run_r;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_pix_r;
  logic             out_last_r, out_done_r;

  logic [PIX_W-1:0] part_nxt, col_px, diff_px;
  logic [2:0]       cnt_inc, need;
  logic             col_done, left_zero, pending, long_op, slot_free, emit_last;
  logic [1:0]       tag;
  logic [7:0]       pr, pg, pb, pa, dg, drg, dbg;
  logic [12:0]      hsum;
  logic [IDX_W-1:0] hash;

  assign pr = prev_r[31:24];
  assign pg = prev_r[23:16];
  assign pb = prev_r[15:8];
  assign pa = prev_r[7:0];

  assign left_zero = (left_r == 32'd0);
  assign pending   = (pend_r != OP_NONE);
  assign long_op   = (byte_r == BYTE_RGB) || (byte_r == BYTE_RGBA);
  assign tag       = byte_r[7:6];
  assign part_nxt  = {part_r[23:0], byte_r};
  assign cnt_inc   = cnt_r + 3'd1;

  always_comb begin
    unique case (pend_r)
      OP_RGB:  need = 3'd3;
      OP_RGBA: need = 3'd4;
      default: need = 3'd1;
    endcase
  end
  assign col_done = (cnt_inc == need);

  assign dg  = {2'b00, part_nxt[13:8]} - 8'd32;
  assign drg = {4'b0000, part_nxt[7:4]} - 8'd8;
  assign dbg = {4'b0000, part_nxt[3:0]} - 8'd8;

  always_comb begin
    unique case (pend_r)
      OP_RGB:  col_px = {part_nxt[23:0], pa};
      OP_RGBA: col_px = part_nxt;
      default: col_px = {pr + drg + dg, pg + dg, pb + dbg + dg, pa};
    endcase
  end

  assign diff_px = {pr + {6'd0, byte_r[5:4]} - 8'd2,
                    pg + {6'd0, byte_r[3:2]} - 8'd2,
                    pb + {6'd0, byte_r[1:0]} - 8'd2, pa};

  assign hsum = 13'(pix_r[31:24]) * 13'd3 + 13'(pix_r[23:16]) * 13'd5
              + 13'(pix_r[15:8]) * 13'd7 + 13'(pix_r[7:0]) * 13'd11;
  assign hash = hsum[IDX_W-1:0];

  assign slot_free = !out_valid_r || out_ready;
  assign emit_last = (run_r == RUN_W'(1)) || (left_r == 32'd1);

  assign sts.dec_idx   = !left_zero && !pending && !long_op && (tag == TAG_INDEX);
  assign sts.dec_emit  = !left_zero && (pending ? col_done
                         : (!long_op && ((tag == TAG_DIFF) || (tag == TAG_RUN))));
  assign sts.slot_free = slot_free;
  assign sts.emit_last = emit_last;

  // color index storage
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      mem[hash] <= pix_r;
    end
    rd_r     <= mem[byte_r[IDX_W-1:0]];
    rd_vld_r <= vld_r[byte_r[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (cmd.accept && in_start) begin
      vld_r <= '0;
    end else if (cmd.emit) begin
      vld_r[hash] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r <= '0;
    end else if (cfg_we) begin
      total_r <= cfg_total;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= OP_NONE;
      cnt_r  <= '0;
      part_r <= '0;
      left_r <= '0;
      prev_r <= RESET_PX;
    end else if (cmd.accept) begin
      if (in_start) begin
        pend_r <= OP_NONE;
        cnt_r  <= '0;
        part_r <= '0;
        left_r <= total_r;
        prev_r <= RESET_PX;
      end
    end else if (cmd.decode && !left_zero) begin
      if (pending) begin
        if (col_done) begin
          pend_r <= OP_NONE;
          cnt_r  <= '0;
          part_r <= '0;
        end else begin
          cnt_r  <= cnt_inc;
          part_r <= part_nxt;
        end
      end else if (long_op) begin
        pend_r <= (byte_r == BYTE_RGB) ? OP_RGB : OP_RGBA;
        cnt_r  <= '0;
        part_r <= '0;
      end else if (tag == TAG_LUMA) begin
        pend_r <= OP_LUMA;
        cnt_r  <= '0;
        part_r <= {24'd0, byte_r};
      end
    end else if (cmd.emit) begin
      prev_r <= pix_r;
      left_r <= left_r - 32'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      byte_r <= in_byte;
    end
    if (cmd.decode) begin
      run_r <= RUN_W'(1);
      if (pending) begin
        pix_r <= col_px;
      end else if (tag == TAG_RUN) begin
        pix_r <= prev_r;
        run_r <= {1'b0, byte_r[5:0]} + RUN_W'(1);
      end else begin
        pix_r <= diff_px;
      end
    end else if (cmd.idx_load) begin
      pix_r <= rd_vld_r ? rd_r : '0;
    end else if (cmd.emit) begin
      run_r <= run_r - RUN_W'(1);
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_pix_r  <= pix_r;
      out_last_r <= emit_last;
      out_done_r <= (left_r == 32'd1);
    end
  end

  assign out_valid = out_valid_r;
  assign out_red   = out_pix_r[31:24];
  assign out_green = out_pix_r[23:16];
  assign out_blue  = out_pix_r[15:8];
  assign out_alpha = out_pix_r[7:0];
  assign out_last  = out_last_r;
  assign out_done  = out_done_r;

endmodule

### src/qcd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qcd_checker
// Port-level assertions of the chunk decoder, bound to the top level.
// ----------------------------------------------------------------------------
module qcd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red,
  input logic [7:0] green,
  input logic [7:0] blue,
  input logic [7:0] alpha,
  input logic       last_of_run,
  input logic       image_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(red) && $stable(green)
      && $stable(blue) && $stable(alpha) && $stable(last_of_run)
      && $stable(image_done))
    else $error("stalled output beat changed");

  a_out_drop: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(out_valid) |-> $past(out_ready))
    else $error("output beat dropped without handshake");

  a_done_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && image_done |-> last_of_run)
    else $error("final pixel without last_of_run");

  a_one_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("byte taken before previous one decoded");

endmodule

bind qoi_chunk_decoder qcd_checker u_qcd_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_bus.valid),
  .in_ready    (in_bus.ready),
  .out_valid   (out_bus.valid),
  .out_ready   (out_bus.ready),
  .red         (out_bus.red),
  .green       (out_bus.green),
  .blue        (out_bus.blue),
  .alpha       (out_bus.alpha),
  .last_of_run (out_bus.last_of_run),
  .image_done  (out_bus.image_done)
);

### test/tb_qoi_chunk_decoder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qoi_chunk_decoder
// Feeds chunk-stream bytes and image sizes to the decoder while a built-in
// decoder predicts every pixel beat, then compares each output beat in order.
// Directed cases cover every op, the field extremes, clipped runs, resizing
// mid-image and restarts inside an op. Random images with random stalls on
// both sides, a long output hold-off and a full-rate stretch follow.
// ----------------------------------------------------------------------------
module tb_qoi_chunk_decoder;
  import qcd_pkg::*;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_run;
    logic       image_done;
  } pixel_beat_t;

  logic clk = 1'b0;
  logic rst_n;

  qcd_in_if  in_if ();
  qcd_out_if out_if ();
  qcd_cfg_if cfg_if ();

  qoi_chunk_decoder dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_bus  (in_if),
    .out_bus (out_if),
    .cfg_bus (cfg_if)
  );

  always #6 clk = ~clk;

  pixel_beat_t pixels_due[$];
  logic [31:0] palette [INDEX_SIZE];
  logic [31:0] last_px;
  logic [1:0]  pend_op;
  int          pend_cnt;
  logic [31:0] pend_bytes;
  logic [31:0] px_left;
  logic [31:0] image_size;

  int bad_beats   = 0;
  int bytes_taken = 0;
  int byte_goal   = 0;
  bit calm        = 1'b0;
  bit hold_req    = 1'b0;

  function automatic logic [5:0] px_hash(input logic [31:0] px);
    int s;
    s = 3 * px[31:24] + 5 * px[23:16] + 7 * px[15:8] + 11 * px[7:0];
    return s[5:0];
  endfunction

  task automatic clear_image();
    foreach (palette[i]) palette[i] = '0;
    last_px    = RESET_PX;
    pend_op    = OP_NONE;
    pend_cnt   = 0;
    pend_bytes = '0;
  endtask

  task automatic emit_pixel(input logic [31:0] px, input logic last);
    palette[px_hash(px)] = px;
    last_px = px;
    if (px_left != 0) px_left--;
    pixels_due.push_back({px, last || px_left == 0, px_left == 0});
  endtask

  task automatic decode_byte(input logic [7:0] b, input logic st);
    logic [7:0]  pr, pg, pb, pa, dg, drg, dbg;
    logic [31:0] px;
    int          need;
    int          run;
    if (st) begin
      clear_image();
      px_left = image_size;
    end
    {pr, pg, pb, pa} = last_px;
    if (px_left == 0) return;
    if (pend_op != OP_NONE) begin
      pend_bytes = {pend_bytes[23:0], b};
      pend_cnt++;
      need = (pend_op == OP_RGB) ? 3 : (pend_op == OP_RGBA) ? 4 : 1;
      if (pend_cnt < need) return;
      case (pend_op)
        OP_RGB:  px = {pend_bytes[23:0], pa};
        OP_RGBA: px = pend_bytes;
        default: begin
          dg  = {2'b00, pend_bytes[13:8]} - 8'd32;
          drg = {4'h0, pend_bytes[7:4]} - 8'd8;
          dbg = {4'h0, pend_bytes[3:0]} - 8'd8;
          px  = {pr + drg + dg, pg + dg, pb + dbg + dg, pa};
        end
      endcase
      pend_op    = OP_NONE;
      pend_cnt   = 0;
      pend_bytes = '0;
      emit_pixel(px, 1'b1);
    end else if (b == BYTE_RGB || b == BYTE_RGBA) begin
      pend_op    = (b == BYTE_RGB) ? OP_RGB : OP_RGBA;
      pend_cnt   = 0;
      pend_bytes = '0;
    end else begin
      case (b[7:6])
        TAG_INDEX: emit_pixel(palette[b[5:0]], 1'b1);
        TAG_DIFF: emit_pixel({pr + b[5:4] - 8'd2, pg + b[3:2] - 8'd2,
                              pb + b[1:0] - 8'd2, pa}, 1'b1);
        TAG_LUMA: begin
          pend_op    = OP_LUMA;
          pend_cnt   = 0;
          pend_bytes = {24'h0, b};
        end
        default: begin
          run = b[5:0] + 1;
          if (run > px_left) run = px_left;
          for (int i = 0; i < run; i++) emit_pixel(last_px, i + 1 == run);
        end
      endcase
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic st);
    int gap;
    gap = (!calm && $urandom_range(0, 5) == 0) ? $urandom_range(1, 11) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.data_byte   <= b;
    in_if.image_start <= st;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    bytes_taken++;
    decode_byte(b, st);
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pixels_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_image_size(input logic [31:0] n);
    wait_idle();
    cfg_if.valid        <= 1'b1;
    cfg_if.total_pixels <= n;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    cfg_if.valid <= 1'b0;
    image_size = n;
  endtask

  task automatic send_op(input bit first);
    logic [7:0] ops[$];
    logic [7:0] rnd8;
    logic [5:0] low6;
    int         kind;
    kind = $urandom_range(0, 15);
    low6 = 6'($urandom_range(0, 63));
    rnd8 = 8'($urandom_range(0, 255));
    case (kind)
      0, 1: begin
        ops.push_back(BYTE_RGB);
        repeat (3) begin
          rnd8 = 8'($urandom_range(0, 255));
          ops.push_back(rnd8);
        end
      end
      2: begin
        ops.push_back(BYTE_RGBA);
        repeat (4) begin
          rnd8 = 8'($urandom_range(0, 255));
          ops.push_back(rnd8);
        end
      end
      3: ops.push_back({TAG_INDEX, px_hash(last_px)});
      4, 5: ops.push_back({TAG_INDEX, low6});
      6, 7, 8: ops.push_back({TAG_DIFF, low6});
      9, 10: begin
        ops.push_back({TAG_LUMA, low6});
        ops.push_back(rnd8);
      end
      11, 12, 13: begin
        low6 = ($urandom_range(0, 5) == 0) ? 6'($urandom_range(0, 61))
                                           : 6'($urandom_range(0, 7));
        ops.push_back({TAG_RUN, low6});
      end
      default: ops.push_back(rnd8);
    endcase
    foreach (ops[i]) send_byte(ops[i], first && i == 0);
  endtask

  task automatic random_image(input bit allow_cut);
    logic [31:0] n;
    logic [7:0]  rnd8;
    int          pick;
    pick = $urandom_range(0, 9);
    n = (pick < 1) ? $urandom_range(1, 2) :
        (pick < 3) ? $urandom_range(41, 150) : $urandom_range(1, 40);
    if (n != image_size) write_image_size(n);
    send_op(1'b1);
    while (px_left != 0 && bytes_taken < byte_goal) begin
      if (allow_cut && $urandom_range(0, 49) == 0) begin
        rnd8 = 8'($urandom_range(0, 255));
        send_byte(BYTE_RGBA, 1'b0);
        send_byte(rnd8, 1'b0);
        return;
      end
      send_op(1'b0);
    end
    repeat ($urandom_range(0, 2)) begin
      rnd8 = 8'($urandom_range(0, 255));
      send_byte(rnd8, 1'b0);
    end
  endtask

  task automatic test_bytes_before_start();
    send_byte(8'hc5, 1'b0);
    send_byte(BYTE_RGB, 1'b0);
  endtask

  task automatic test_empty_image();
    write_image_size(32'd0);
    send_byte(8'h41, 1'b1);
    send_byte(8'hc3, 1'b0);
  endtask

  task automatic test_every_op();
    write_image_size(32'd20);
    send_byte(BYTE_RGB, 1'b1);
    send_byte(8'h00, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte(8'h80, 1'b0);
    send_byte(BYTE_RGBA, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h34, 1'b0);
    send_byte(8'h56, 1'b0);
    send_byte(8'h78, 1'b0);
    send_byte({TAG_DIFF, 6'h00}, 1'b0);
    send_byte({TAG_DIFF, 6'h3f}, 1'b0);
    send_byte({TAG_LUMA, 6'h00}, 1'b0);
    send_byte(8'h00, 1'b0);
    send_byte({TAG_LUMA, 6'h3f}, 1'b0);
    send_byte(8'hff, 1'b0);
    send_byte({TAG_INDEX, 6'h00}, 1'b0);
    send_byte({TAG_INDEX, px_hash(32'h1234_5678)}, 1'b0);
    send_byte({TAG_RUN, 6'h00}, 1'b0);
  endtask

  // count change is held until the next start, long run is clipped
  task automatic test_size_change_mid_image();
    write_image_size(32'd5);
    send_byte({TAG_RUN, 6'h3d}, 1'b0);
    send_byte(8'h41, 1'b0);
  endtask

  task automatic test_restart_inside_op();
    send_byte(8'h55, 1'b1);
    send_byte(BYTE_RGB, 1'b0);
    send_byte(8'h12, 1'b0);
    send_byte(8'h7f, 1'b1);
    send_byte({TAG_RUN, 6'h07}, 1'b0);
  endtask

  task automatic test_huge_image();
    write_image_size(32'hffff_ffff);
    send_op(1'b1);
    repeat (30) send_op(1'b0);
  endtask

  task automatic test_output_hold();
    write_image_size(32'd400);
    hold_req = 1'b1;
    send_byte(BYTE_RGB, 1'b1);
    send_byte(8'ha5, 1'b0);
    send_byte(8'h5a, 1'b0);
    send_byte(8'h3c, 1'b0);
    repeat (6) begin
      send_byte({TAG_RUN, 6'd40}, 1'b0);
      send_byte({TAG_DIFF, 6'h2b}, 1'b0);
    end
  endtask

  task automatic test_random_images();
    byte_goal = bytes_taken + 340;
    while (bytes_taken < byte_goal) random_image(1'b1);
  endtask

  task automatic test_full_rate();
    wait_idle();
    calm = 1'b1;
    byte_goal = bytes_taken + 60;
    while (bytes_taken < byte_goal) random_image(1'b0);
  endtask

  // output ready: random stalls, one long hold on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end else begin
        out_if.ready <= 1'b1;
      end
    end
  end

  initial begin
    pixel_beat_t got;
    pixel_beat_t want;
    forever begin
      @(posedge clk);
      if (out_if.valid && out_if.ready) begin
        got = {out_if.red, out_if.green, out_if.blue, out_if.alpha,
               out_if.last_of_run, out_if.image_done};
        if (pixels_due.size() == 0) begin
          bad_beats++;
          if (bad_beats <= 40)
            $display("%0t: unexpected beat, expected none, got %h", $time, got);
        end else begin
          want = pixels_due.pop_front();
          if (got !== want) begin
            bad_beats++;
            if (bad_beats <= 40)
              $display("%0t: expected rgba %h%h%h%h last %b done %b, got rgba %h%h%h%h last %b done %b",
                       $time, want.red, want.green, want.blue, want.alpha,
                       want.last_of_run, want.image_done, got.red, got.green, got.blue,
                       got.alpha, got.last_of_run, got.image_done);
          end
        end
      end
    end
  end

  initial begin
    #60_000_000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    rst_n               <= 1'b0;
    in_if.valid         <= 1'b0;
    in_if.data_byte     <= 8'h00;
    in_if.image_start   <= 1'b0;
    cfg_if.valid        <= 1'b0;
    cfg_if.total_pixels <= 32'd0;
    image_size = '0;
    px_left    = '0;
    clear_image();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_bytes_before_start();
    test_empty_image();
    test_every_op();
    test_size_change_mid_image();
    test_restart_inside_op();
    test_huge_image();
    test_output_hold();
    test_random_images();
    test_full_rate();

    wait_idle();
    repeat (16) @(posedge clk);
    if (bad_beats == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
